>>> sv/sfd_pkg.sv
// Shared types and constants for the stereo feedback delay.
package sfd_pkg;

   localparam int GAIN_BITS  = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DELAY_BITS = 17;
   localparam int CSR_IDX_BITS = 3;
   localparam logic [FRAC_BITS:0] ROUND_HALF = 17'd32768;

   localparam logic                  ENABLE_RST   = 1'b1;
   localparam logic                  WET_ONLY_RST = 1'b0;
   localparam logic [DELAY_BITS-1:0] DELAY_RST    = 17'd24000;
   localparam logic [GAIN_BITS-1:0]  FB_GAIN_RST  = 16'd32768;
   localparam logic [GAIN_BITS-1:0]  MIX_GAIN_RST = 16'd32768;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE   = 3'd0,
      CSR_WET_ONLY = 3'd1,
      CSR_DELAY    = 3'd2,
      CSR_FB_GAIN  = 3'd3,
      CSR_MIX_GAIN = 3'd4
   } sfd_csr_type;

   // stage strobes and settings shared by both channel datapaths
   typedef struct packed {
      logic                 rd;
      logic                 mul;
      logic                 wr;
      logic                 en;
      logic                 wet_only;
      logic [GAIN_BITS-1:0] fb_gain;
      logic [GAIN_BITS-1:0] mix_gain;
   } sfd_ctl_type;

endpackage

>>> sv/sfd_chan.sv
// One channel: delay memory, forwarding, gain multipliers and saturating writeback.
module sfd_chan import sfd_pkg::*; #(
   parameter int STORE_DEPTH = 131072,
   parameter int SAMPLE_BITS = 24,
   localparam int AW = $clog2(STORE_DEPTH)
) (
   input  logic                          clock,
   input  sfd_ctl_type                   ctl,
   input  logic [AW-1:0]                 rd_addr,
   input  logic                          rd_ok,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [AW-1:0]                 wr_addr,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   output logic                          out_clip
);

   localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SW = SAMPLE_BITS + 2;

   logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   logic [AW-1:0]                 rd_addr_s1_ff;
   logic                          ok_s1_ff;
   logic signed [SAMPLE_BITS-1:0] x_s1_ff;
   logic signed [SAMPLE_BITS-1:0] x_s2_ff;

   logic [AW-1:0]          lw_addr_ff;
   logic [SAMPLE_BITS-1:0] lw_data_ff;

   logic signed [PW-1:0] fbp_ff, fbp_in;
   logic signed [PW-1:0] mixp_ff, mixp_in;

   logic signed [SAMPLE_BITS-1:0] delayed;
   logic signed [PW-1:0]          dly_ext;
   logic signed [PW-1:0]          fb_ext;
   logic signed [PW-1:0]          mix_ext;

   logic signed [PW-1:0]          fb_round;
   logic signed [PW-1:0]          mix_round;
   logic signed [SW-1:0]          fb_scaled;
   logic signed [SW-1:0]          wet_scaled;
   logic signed [SW-1:0]          x_ext;
   logic signed [SW-1:0]          back_sum;
   logic signed [SW-1:0]          wet_sum;
   logic [SAMPLE_BITS-1:0]        back;

   function automatic logic ovf(input logic [SW-1:0] v);
      ovf = !((v[SW-1:SAMPLE_BITS-1] == '0) || (v[SW-1:SAMPLE_BITS-1] == '1));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat(input logic [SW-1:0] v);
      if (!ovf(v)) begin
         sat = v[SAMPLE_BITS-1:0];
      end else if (v[SW-1]) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // memory: read-first on a same-address write
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         store_mem[wr_addr] <= back;
      end
      if (ctl.rd) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_addr_s1_ff <= rd_addr;
         ok_s1_ff      <= rd_ok;
         x_s1_ff       <= sample;
      end
      if (ctl.mul) begin
         fbp_ff  <= fbp_in;
         mixp_ff <= mixp_in;
         x_s2_ff <= x_s1_ff;
      end
      if (ctl.wr) begin
         lw_addr_ff <= wr_addr;
         lw_data_ff <= back;
      end
   end

   // never-written slots read as zero; the last write is forwarded past the memory
   always_comb begin
      if (!ok_s1_ff) begin
         delayed = '0;
      end else if (rd_addr_s1_ff == lw_addr_ff) begin
         delayed = lw_data_ff;
      end else begin
         delayed = rdata_ff;
      end
   end

   assign dly_ext = PW'(delayed);
   assign fb_ext  = PW'({1'b0, ctl.fb_gain});
   assign mix_ext = PW'({1'b0, ctl.mix_gain});
   assign fbp_in  = dly_ext * fb_ext;
   assign mixp_in = dly_ext * mix_ext;

   assign fb_round   = fbp_ff + PW'(ROUND_HALF);
   assign mix_round  = mixp_ff + PW'(ROUND_HALF);
   assign fb_scaled  = SW'($signed(fb_round[PW-1:FRAC_BITS]));
   assign wet_scaled = SW'($signed(mix_round[PW-1:FRAC_BITS]));
   assign x_ext      = SW'(x_s2_ff);
   assign back_sum   = x_ext + fb_scaled;
   assign wet_sum    = ctl.wet_only ? wet_scaled : x_ext + wet_scaled;
   assign back       = sat(back_sum);

   assign out_sample = ctl.en ? $signed(sat(wet_sum)) : x_s2_ff;
   assign out_clip   = ctl.en && (ovf(back_sum) || ovf(wet_sum));

endmodule

>>> sv/stereo_feedback_delay_top.sv
// Stereo feedback delay: control, write position, fill tracking and result register.
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata: sample_left, sample_right
//  rsp_     out  rsp_tvalid/tready    tdata: out_left, out_right; tuser: clipped
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
// The feedback loop (memory read or forward, multiply, add and saturate, write) spans two
// register stages, so a pair enters only while stage 1 is empty. rsp_tvalid rises once the
// pair has passed stages 1 and 2 into the result register; a held result register still lets
// the next pair in. No clearing pass after reset: a fill count makes unwritten slots read zero.
// STORE_DEPTH must be a power of two. Reset is synchronous; csr_ready is always high.
module stereo_feedback_delay_top import sfd_pkg::*; #(
   parameter int STORE_DEPTH = 131072,
   parameter int SAMPLE_BITS = 24,
   localparam int AW = $clog2(STORE_DEPTH),
   localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [DW-1:0]           req_tdata,   // sample_left, sample_right
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [DW-1:0]           rsp_tdata,   // out_left, out_right
   output logic                    rsp_tuser,   // clipped
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [DELAY_BITS-1:0]   csr_data
);

   localparam int SB = SAMPLE_BITS;
   localparam logic [AW:0] DEPTH = (AW+1)'(STORE_DEPTH);

   logic                  en_ff;
   logic                  wet_ff;
   logic [DELAY_BITS-1:0] delay_ff;
   logic [GAIN_BITS-1:0]  fb_ff;
   logic [GAIN_BITS-1:0]  mix_ff;

   logic [AW-1:0] wp_ff, wp_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [AW-1:0] wp_s1_ff;
   logic [AW-1:0] wp_s2_ff;

   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic rsp_vld_ff, rsp_vld_in;

   logic signed [SB-1:0] rsp_l_ff;
   logic signed [SB-1:0] rsp_r_ff;
   logic                 rsp_clip_ff;

   logic out_free;
   logic s2_done;
   logic accept;

   logic [AW+DELAY_BITS-1:0] dly_wide;
   logic [AW-1:0]            dly;
   logic [AW:0]              dly_eff;
   logic [AW-1:0]            rd_addr;
   logic                     rd_ok;

   sfd_ctl_type ctl;

   logic signed [SB-1:0] out_l;
   logic signed [SB-1:0] out_r;
   logic                 clip_l;
   logic                 clip_r;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= ENABLE_RST;
         wet_ff   <= WET_ONLY_RST;
         delay_ff <= DELAY_RST;
         fb_ff    <= FB_GAIN_RST;
         mix_ff   <= MIX_GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (sfd_csr_type'(csr_index))
            CSR_ENABLE:   en_ff    <= csr_data[0];
            CSR_WET_ONLY: wet_ff   <= csr_data[0];
            CSR_DELAY:    delay_ff <= csr_data;
            CSR_FB_GAIN:  fb_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_MIX_GAIN: mix_ff   <= csr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s2_done    = s2_vld_ff && out_free;
   assign req_tready = !s1_vld_ff && (!s2_vld_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   assign s1_vld_in  = accept;
   assign s2_vld_in  = s1_vld_ff || (s2_vld_ff && !out_free);
   assign rsp_vld_in = s2_done || (rsp_vld_ff && !rsp_tready);

   // read slot and whether it has been written since reset
   assign dly_wide = (AW+DELAY_BITS)'(delay_ff);
   assign dly      = dly_wide[AW-1:0];
   assign dly_eff  = (dly == '0) ? DEPTH : {1'b0, dly};
   assign rd_addr  = wp_ff - dly;
   assign rd_ok    = dly_eff <= fill_ff;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (accept && en_ff) begin
         wp_in = wp_ff + 1'b1;
         if (fill_ff != DEPTH) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         fill_ff    <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wp_s1_ff <= wp_ff;
      end
      if (s1_vld_ff) begin
         wp_s2_ff <= wp_s1_ff;
      end
      if (s2_done) begin
         rsp_l_ff    <= out_l;
         rsp_r_ff    <= out_r;
         rsp_clip_ff <= clip_l || clip_r;
      end
   end

   always_comb begin
      ctl          = '0;
      ctl.rd       = accept;
      ctl.mul      = s1_vld_ff;
      ctl.wr       = s2_done && en_ff;
      ctl.en       = en_ff;
      ctl.wet_only = wet_ff;
      ctl.fb_gain  = fb_ff;
      ctl.mix_gain = mix_ff;
   end

   sfd_chan #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left (
      .clock      (clock),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .rd_ok      (rd_ok),
      .sample     ($signed(req_tdata[SB-1:0])),
      .wr_addr    (wp_s2_ff),
      .out_sample (out_l),
      .out_clip   (clip_l)
   );

   sfd_chan #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right (
      .clock      (clock),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .rd_ok      (rd_ok),
      .sample     ($signed(req_tdata[2*SB-1:SB])),
      .wr_addr    (wp_s2_ff),
      .out_sample (out_r),
      .out_clip   (clip_r)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = DW'({rsp_r_ff, rsp_l_ff});
   assign rsp_tuser  = rsp_clip_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH)
      else $error("fill count beyond store depth");

   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff ##1 s2_vld_ff)
      else $error("accepted pair lost in pipeline");

   a_one_in_loop: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |=> !s1_vld_ff)
      else $error("pairs entered back to back, forwarding unsafe");

   a_result_out: assert property (@(posedge clock) disable iff (reset)
      s2_done |=> rsp_vld_ff)
      else $error("finished pair not presented");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept && en_ff |=> wp_ff == AW'($past(wp_ff) + 1'b1))
      else $error("write position did not advance");

endmodule
